>>> rtl/pol_pkg.sv
// Package with the shared types, widths and helper functions of the positional ordered list.
`default_nettype none
package pol_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    localparam int MODE_W  = 2;
    localparam int POS_W   = 5;
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 2;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [DATA_WIDTH-1:0] t_data;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_READ   = 2'd2
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LOWER,
        CELL_FROM_UPPER
    } t_cell_op;

    function automatic t_data to_cell(logic signed [VAL_W-1:0] v);
        return DATA_WIDTH'(v);
    endfunction

    function automatic logic signed [VAL_W-1:0] from_cell(t_data d);
        logic signed [DATA_WIDTH-1:0] s;
        s = d;
        return VAL_W'(s);
    endfunction

endpackage
`default_nettype wire

>>> rtl/pol_if.sv
// Handshake interfaces for the command and response channels of the positional ordered list.
`default_nettype none
interface pol_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic [pol_pkg::MODE_W-1:0]           mode;
    logic [pol_pkg::POS_W-1:0]            position;
    logic signed [pol_pkg::VAL_W-1:0]     item_value;

    modport source (output valid, mode, position, item_value, input ready);
    modport sink   (input valid, mode, position, item_value, output ready);
endinterface

interface pol_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pol_pkg::VAL_W-1:0]     read_value;
    logic [pol_pkg::COUNT_W-1:0]          count;
    logic [pol_pkg::STAT_W-1:0]           status;

    modport source (output valid, read_value, count, status, input ready);
    modport sink   (input valid, read_value, count, status, output ready);
endinterface
`default_nettype wire

>>> rtl/pol_cell.sv
// One storage cell of the list chain, loading a new value or taking a neighbour's value.
`default_nettype none
module pol_cell (
    input  wire logic              i_clk,
    input  pol_pkg::t_cell_op      i_op,
    input  pol_pkg::t_data         i_value,
    input  pol_pkg::t_data         i_lower,
    input  pol_pkg::t_data         i_upper,
    output pol_pkg::t_data         o_data
);

    pol_pkg::t_data r_data;
    pol_pkg::t_data n_data;

    always_comb begin
        case (i_op)
            pol_pkg::CELL_LOAD:       n_data = i_value;
            pol_pkg::CELL_FROM_LOWER: n_data = i_lower;
            pol_pkg::CELL_FROM_UPPER: n_data = i_upper;
            default:                  n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

>>> rtl/positional_ordered_list_top.sv
// Top level of the positional ordered list: command decode, cell chain and response register.
// The block keeps an ordered list of up to CAPACITY values in a chain of cells, cell 0 the head.
// Commands arrive on i_cmd (mode, position, item_value) and each one yields exactly one
// response transfer on o_rsp carrying read_value, count and status.
// Insert puts a value before the element at the position, or appends it when the position is
// at or past the length; remove takes out the element at the position, clamped to the tail;
// read returns the element at the position.
// Every cell decides in the same cycle whether it holds, loads the new value or takes the value
// of its lower or upper neighbour, so an insert or remove anywhere in the list shifts all cells at once.
// The response to an accepted command appears in the response register in the next cycle.
// Throughput is one command per cycle while the receiver takes every response.
// When the receiver stalls, the response register holds its transfer and i_cmd.ready falls
// until that response is taken, so at most one response waits.
// Synchronous reset empties the list and drops any waiting response; no clearing pass is
// needed, as only cells below the current length are ever read.
`default_nettype none
module positional_ordered_list_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pol_cmd_if.sink    i_cmd,
    pol_rsp_if.source  o_rsp
);

    logic [pol_pkg::CNT_W-1:0]          r_used;
    logic [pol_pkg::CNT_W-1:0]          n_used;
    logic                               r_out_valid;
    logic                               n_out_valid;
    logic signed [pol_pkg::VAL_W-1:0]   r_out_read_value;
    logic signed [pol_pkg::VAL_W-1:0]   n_out_read_value;
    pol_pkg::t_status                   r_out_status;
    pol_pkg::t_status                   n_out_status;

    logic                               w_accept;
    pol_pkg::t_mode                     w_mode;
    logic                               w_full;
    logic                               w_empty;
    logic [pol_pkg::CMP_W-1:0]          w_pos;
    logic [pol_pkg::CMP_W-1:0]          w_used;
    logic [pol_pkg::CMP_W-1:0]          w_last;
    logic [pol_pkg::CMP_W-1:0]          w_at;
    logic [pol_pkg::IDX_W-1:0]          w_read_idx;
    pol_pkg::t_data                     w_value;
    pol_pkg::t_data                     w_data [pol_pkg::CAPACITY];
    pol_pkg::t_cell_op                  w_op   [pol_pkg::CAPACITY];

    assign i_cmd.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_mode      = pol_pkg::t_mode'(i_cmd.mode);

    assign w_pos   = pol_pkg::CMP_W'(i_cmd.position);
    assign w_used  = pol_pkg::CMP_W'(r_used);
    assign w_last  = pol_pkg::CMP_W'(w_used - pol_pkg::CMP_W'(1));
    assign w_full  = (r_used == pol_pkg::CNT_W'(pol_pkg::CAPACITY));
    assign w_empty = (r_used == '0);
    assign w_value = pol_pkg::to_cell(i_cmd.item_value);
    assign w_read_idx = pol_pkg::IDX_W'(w_pos);

    always_comb begin
        if (w_mode == pol_pkg::MODE_REMOVE) begin
            w_at = (w_pos < w_last) ? w_pos : w_last;
        end else begin
            w_at = (w_pos < w_used) ? w_pos : w_used;
        end
    end

    for (genvar k = 0; k < pol_pkg::CAPACITY; k++) begin : g_cell
        pol_pkg::t_data w_lower;
        pol_pkg::t_data w_upper;

        always_comb begin
            w_op[k] = pol_pkg::CELL_HOLD;
            if (w_accept) begin
                case (w_mode)
                    pol_pkg::MODE_INSERT: begin
                        if (!w_full) begin
                            if (w_at == pol_pkg::CMP_W'(k)) begin
                                w_op[k] = pol_pkg::CELL_LOAD;
                            end else if (w_at < pol_pkg::CMP_W'(k)) begin
                                w_op[k] = pol_pkg::CELL_FROM_LOWER;
                            end
                        end
                    end
                    pol_pkg::MODE_REMOVE: begin
                        if (!w_empty && (w_at <= pol_pkg::CMP_W'(k))) begin
                            w_op[k] = pol_pkg::CELL_FROM_UPPER;
                        end
                    end
                    default: begin
                        w_op[k] = pol_pkg::CELL_HOLD;
                    end
                endcase
            end
        end

        if (k == 0) begin : g_head
            assign w_lower = w_value;
        end else begin : g_body
            assign w_lower = w_data[k-1];
        end

        if (k == pol_pkg::CAPACITY - 1) begin : g_tail
            assign w_upper = w_data[k];
        end else begin : g_inner
            assign w_upper = w_data[k+1];
        end

        pol_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op[k]),
            .i_value (w_value),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .o_data  (w_data[k])
        );
    end

    always_comb begin
        n_used           = r_used;
        n_out_status     = pol_pkg::ST_OK;
        n_out_read_value = '0;
        case (w_mode)
            pol_pkg::MODE_INSERT: begin
                if (w_full) begin
                    n_out_status = pol_pkg::ST_FULL;
                end else begin
                    n_used = pol_pkg::CNT_W'(r_used + pol_pkg::CNT_W'(1));
                end
            end
            pol_pkg::MODE_REMOVE: begin
                if (w_empty) begin
                    n_out_status = pol_pkg::ST_EMPTY;
                end else begin
                    n_used = pol_pkg::CNT_W'(r_used - pol_pkg::CNT_W'(1));
                end
            end
            pol_pkg::MODE_READ: begin
                if (w_pos >= w_used) begin
                    n_out_status = pol_pkg::ST_RANGE;
                end else begin
                    n_out_read_value = pol_pkg::from_cell(w_data[w_read_idx]);
                end
            end
            default: begin
                n_out_status = pol_pkg::ST_OK;
            end
        endcase
    end

    assign n_out_valid = w_accept || (r_out_valid && !o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_accept) begin
                r_used <= n_used;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_read_value <= n_out_read_value;
            r_out_status     <= n_out_status;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_value = r_out_read_value;
    assign o_rsp.count      = pol_pkg::COUNT_W'(r_used);
    assign o_rsp.status     = r_out_status;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= pol_pkg::CNT_W'(pol_pkg::CAPACITY))
        else $error("List length exceeds the capacity.");

    a_full_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (w_mode == pol_pkg::MODE_INSERT) && w_full
        |=> (r_out_status == pol_pkg::ST_FULL) && $stable(r_used))
        else $error("Insert into a full list did not report full or changed the length.");

    a_empty_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (w_mode == pol_pkg::MODE_REMOVE) && w_empty
        |=> (r_out_status == pol_pkg::ST_EMPTY) && (r_used == '0))
        else $error("Remove from an empty list did not report empty.");

    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status != pol_pkg::ST_OK) |-> (r_out_read_value == '0))
        else $error("A response with an error status carries a non-zero value.");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_rsp.ready |=> r_out_valid && $stable(r_used))
        else $error("A stalled response was lost or the list changed during the stall.");

endmodule
`default_nettype wire

>>> tb/sv/positional_ordered_list_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the positional ordered list with a shadow list and random handshakes.
module positional_ordered_list_top_tb;

    localparam logic [pol_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1625;
    localparam int QUIET_ITEMS  = 150;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic signed [pol_pkg::VAL_W-1:0] read_value;
        logic [pol_pkg::COUNT_W-1:0]      count;
        pol_pkg::t_status                 status;
    } t_list_rsp;

    typedef enum {BIAS_FILL, BIAS_DRAIN, BIAS_MIXED} t_bias;

    class t_list_mirror;
        pol_pkg::t_data cells [pol_pkg::CAPACITY];
        int unsigned    used;
        t_list_rsp      pending_responses [$];
        int unsigned    errors;
        int unsigned    mode_seen [4];
        int unsigned    status_seen [4];

        function void note_command(logic [pol_pkg::MODE_W-1:0] m,
                                   logic [pol_pkg::POS_W-1:0] p,
                                   logic signed [pol_pkg::VAL_W-1:0] v);
            t_list_rsp rsp;
            int unsigned at;
            logic signed [pol_pkg::DATA_WIDTH-1:0] stored;
            rsp.read_value = '0;
            rsp.status     = pol_pkg::ST_OK;
            case (m)
                pol_pkg::MODE_INSERT: begin
                    if (used >= pol_pkg::CAPACITY) begin
                        rsp.status = pol_pkg::ST_FULL;
                    end else begin
                        at = (p < used) ? p : used;
                        for (int i = used; i > at; i--) cells[i] = cells[i-1];
                        cells[at] = pol_pkg::DATA_WIDTH'(v);
                        used++;
                    end
                end
                pol_pkg::MODE_REMOVE: begin
                    if (used == 0) begin
                        rsp.status = pol_pkg::ST_EMPTY;
                    end else begin
                        at = (p < used - 1) ? p : used - 1;
                        for (int i = at; i + 1 < used; i++) cells[i] = cells[i+1];
                        used--;
                    end
                end
                pol_pkg::MODE_READ: begin
                    if (p >= used) begin
                        rsp.status = pol_pkg::ST_RANGE;
                    end else begin
                        stored         = cells[p];
                        rsp.read_value = pol_pkg::VAL_W'(stored);
                    end
                end
                default: begin
                end
            endcase
            rsp.count = pol_pkg::COUNT_W'(used);
            mode_seen[m]++;
            status_seen[rsp.status]++;
            pending_responses.push_back(rsp);
        endfunction

        function void check_response(logic signed [pol_pkg::VAL_W-1:0] rv,
                                     logic [pol_pkg::COUNT_W-1:0] cnt,
                                     logic [pol_pkg::STAT_W-1:0] st);
            t_list_rsp exp_rsp;
            if (pending_responses.size() == 0) begin
                $error("response transfer with no command outstanding");
                errors++;
                return;
            end
            exp_rsp = pending_responses.pop_front();
            if (rv !== exp_rsp.read_value) begin
                $error("read_value mismatch: expected %0d, actual %0d", exp_rsp.read_value, rv);
                errors++;
            end
            if (cnt !== exp_rsp.count) begin
                $error("count mismatch: expected %0d, actual %0d", exp_rsp.count, cnt);
                errors++;
            end
            if (st !== exp_rsp.status) begin
                $error("status mismatch: expected %0d, actual %0d", exp_rsp.status, st);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit   sender_idle_en = 1'b1;
    bit   receiver_idle_en = 1'b1;
    bit   long_hold_req = 1'b0;
    int unsigned cycle_count = 0;
    t_list_mirror mirror = new();

    pol_cmd_if cmd_bus();
    pol_rsp_if rsp_bus();

    positional_ordered_list_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    always #5 i_clk = ~i_clk;

    task automatic issue_command(input logic [pol_pkg::MODE_W-1:0] m,
                                 input logic [pol_pkg::POS_W-1:0] p,
                                 input logic signed [pol_pkg::VAL_W-1:0] v);
        if (sender_idle_en && $urandom_range(0, 4) == 0) begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.mode       <= m;
        cmd_bus.position   <= p;
        cmd_bus.item_value <= v;
        do @(posedge i_clk); while (!cmd_bus.ready);
        mirror.note_command(m, p, v);
    endtask

    always @(posedge i_clk) begin
        if (rsp_bus.valid && rsp_bus.ready) begin
            mirror.check_response(rsp_bus.read_value, rsp_bus.count, rsp_bus.status);
        end
    end

    initial begin
        int stall_left;
        stall_left = 0;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD - 1;
                rsp_bus.ready <= 1'b0;
            end else if (receiver_idle_en && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 6);
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        t_bias bias;
        int unsigned r;
        logic [pol_pkg::MODE_W-1:0] m;
        logic [pol_pkg::POS_W-1:0] p;
        logic signed [pol_pkg::VAL_W-1:0] v;
        cmd_bus.valid      <= 1'b0;
        cmd_bus.mode       <= pol_pkg::MODE_INSERT;
        cmd_bus.position   <= '0;
        cmd_bus.item_value <= '0;
        bias = BIAS_FILL;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty list cases, then fill to capacity with extreme values at head, tail and middle.
        issue_command(pol_pkg::MODE_REMOVE, 5'd0, 32'sd0);
        issue_command(pol_pkg::MODE_READ, 5'd0, 32'sd0);
        issue_command(MODE_UNUSED, 5'd16, -32'sd1);
        for (int i = 0; i < pol_pkg::CAPACITY; i++) begin
            case (i)
                0: v = 32'h7fff_ffff;
                1: v = 32'h8000_0000;
                2: v = 32'hffff_ffff;
                3: v = 32'h0000_0000;
                default: v = $urandom;
            endcase
            case (i % 3)
                0: p = 5'd16;
                1: p = 5'd0;
                default: p = pol_pkg::POS_W'($urandom_range(0, i));
            endcase
            issue_command(pol_pkg::MODE_INSERT, p, v);
        end
        issue_command(pol_pkg::MODE_INSERT, 5'd3, 32'sd12345);
        issue_command(pol_pkg::MODE_READ, 5'd15, 32'sd0);
        issue_command(pol_pkg::MODE_READ, 5'd16, 32'sd0);
        issue_command(pol_pkg::MODE_REMOVE, 5'd16, 32'sd0);
        issue_command(pol_pkg::MODE_REMOVE, 5'd0, 32'sd0);
        issue_command(pol_pkg::MODE_REMOVE, 5'd5, 32'sd0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) bias = t_bias'($urandom_range(0, 2));
            if (n == 100 || n == 900) long_hold_req = 1'b1;
            if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
                sender_idle_en   = 1'b0;
                receiver_idle_en = 1'b0;
            end
            r = $urandom_range(0, 99);
            case (bias)
                BIAS_FILL:  m = (r < 60) ? pol_pkg::MODE_INSERT :
                                (r < 75) ? pol_pkg::MODE_REMOVE :
                                (r < 98) ? pol_pkg::MODE_READ : MODE_UNUSED;
                BIAS_DRAIN: m = (r < 20) ? pol_pkg::MODE_INSERT :
                                (r < 70) ? pol_pkg::MODE_REMOVE :
                                (r < 98) ? pol_pkg::MODE_READ : MODE_UNUSED;
                default:    m = (r < 35) ? pol_pkg::MODE_INSERT :
                                (r < 65) ? pol_pkg::MODE_REMOVE :
                                (r < 98) ? pol_pkg::MODE_READ : MODE_UNUSED;
            endcase
            if ($urandom_range(0, 9) < 6) p = pol_pkg::POS_W'($urandom_range(0, mirror.used));
            else p = pol_pkg::POS_W'($urandom_range(0, 16));
            case ($urandom_range(0, 15))
                0: v = 32'h8000_0000;
                1: v = 32'h7fff_ffff;
                2: v = 32'h0000_0000;
                3: v = 32'hffff_ffff;
                default: v = $urandom;
            endcase
            issue_command(m, p, v);
        end
        cmd_bus.valid <= 1'b0;

        while (mirror.pending_responses.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("Commands sent: %0d insert, %0d remove, %0d read, %0d unused selector.",
                 mirror.mode_seen[pol_pkg::MODE_INSERT], mirror.mode_seen[pol_pkg::MODE_REMOVE],
                 mirror.mode_seen[pol_pkg::MODE_READ], mirror.mode_seen[MODE_UNUSED]);
        $display("Outcomes: %0d ok, %0d full, %0d empty, %0d out of range; %0d mismatches.",
                 mirror.status_seen[pol_pkg::ST_OK], mirror.status_seen[pol_pkg::ST_FULL],
                 mirror.status_seen[pol_pkg::ST_EMPTY], mirror.status_seen[pol_pkg::ST_RANGE],
                 mirror.errors);
        if (mirror.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> positional_ordered_list_top.f
rtl/pol_pkg.sv
rtl/pol_if.sv
rtl/pol_cell.sv
rtl/positional_ordered_list_top.sv
tb/sv/positional_ordered_list_top_tb.sv
